// File: hdl/atbd_pkg.sv
// Shared types and constants of the ATASCII byte decoder.
// Holds the action codes, byte codes, glyph map and the control structs.
// No dependencies.
package atbd_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int TAB_SPACING = 8;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int CNT_W       = COL_W + 1;
	localparam int SCOLS_W     = 9;
	localparam logic [SCOLS_W-1:0] SCOLS_RESET = SCOLS_W'(80);

	typedef enum logic [4:0] {
		ACT_GLYPH      = 5'd0,
		ACT_ESC        = 5'd1,
		ACT_UP         = 5'd2,
		ACT_DOWN       = 5'd3,
		ACT_LEFT       = 5'd4,
		ACT_RIGHT      = 5'd5,
		ACT_CLEAR_HOME = 5'd6,
		ACT_BACKSPACE  = 5'd7,
		ACT_NEWLINE    = 5'd8,
		ACT_ERASE_EOL  = 5'd9,
		ACT_INS_LINE   = 5'd10,
		ACT_TAB_CLEAR  = 5'd11,
		ACT_TAB_SET    = 5'd12,
		ACT_BELL       = 5'd13,
		ACT_DELETE     = 5'd14,
		ACT_INS_BLANK  = 5'd15,
		ACT_RESET      = 5'd16
	} action_t;

	localparam logic [7:0] BYTE_ESC       = 8'h1B;
	localparam logic [7:0] BYTE_UP        = 8'h1C;
	localparam logic [7:0] BYTE_DOWN      = 8'h1D;
	localparam logic [7:0] BYTE_LEFT      = 8'h1E;
	localparam logic [7:0] BYTE_RIGHT     = 8'h1F;
	localparam logic [7:0] BYTE_CLEAR     = 8'h7D;
	localparam logic [7:0] BYTE_BACKSPACE = 8'h7E;
	localparam logic [7:0] BYTE_TAB       = 8'h7F;
	localparam logic [7:0] BYTE_EOL       = 8'h9B;
	localparam logic [7:0] BYTE_ERASE_EOL = 8'h9C;
	localparam logic [7:0] BYTE_INS_LINE  = 8'h9D;
	localparam logic [7:0] BYTE_TAB_CLEAR = 8'h9E;
	localparam logic [7:0] BYTE_TAB_SET   = 8'h9F;
	localparam logic [7:0] BYTE_BELL      = 8'hFD;
	localparam logic [7:0] BYTE_DELETE    = 8'hFE;
	localparam logic [7:0] BYTE_INS_BLANK = 8'hFF;

	localparam logic [15:0] GLYPH_ROM [128] = '{
		16'h2665, 16'h251C, 16'h23B9, 16'h2518, 16'h2524, 16'h2510, 16'h2571, 16'h2572,
		16'h25E2, 16'h2597, 16'h25E3, 16'h259D, 16'h2598, 16'h23BA, 16'h23BD, 16'h2596,
		16'h2663, 16'h250C, 16'h2500, 16'h253C, 16'h25CF, 16'h2584, 16'h23B8, 16'h252C,
		16'h2534, 16'h258C, 16'h2514, 16'h241B, 16'h2191, 16'h2193, 16'h2190, 16'h2192,
		16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
		16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
		16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
		16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
		16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
		16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
		16'h2666, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
		16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
		16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
		16'h0078, 16'h0079, 16'h007A, 16'h2660, 16'h007C, 16'h2196, 16'h25C0, 16'h25B6
	};

	// Decoded form of one item.
	typedef struct packed {
		action_t     action;
		logic [15:0] glyph;
		logic        rev;
		logic        right_one;
		logic        tab;
		logic        esc_toggle;
		logic        emu_reset;
		logic        stop_set;
		logic        stop_clr;
	} dec_t;

	// Tab-stop map update request.
	typedef struct packed {
		logic load_default;
		logic stop_set;
		logic stop_clr;
	} tab_op_t;

endpackage

// File: hdl/atbd_if.sv
// Channel interfaces of the ATASCII byte decoder: request, result, config write.
// Depends on atbd_pkg for widths.
interface atbd_req_if import atbd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	logic [7:0] cursor_column;

	modport source (output valid, req_type, data_byte, cursor_column, input ready);
	modport sink (input valid, req_type, data_byte, cursor_column, output ready);
endinterface

interface atbd_res_if import atbd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic [15:0] glyph_code;
	logic        reverse_video;
	logic [7:0]  move_count;
	logic        escape_flag;

	modport source (output valid, action, glyph_code, reverse_video, move_count,
		escape_flag, input ready);
	modport sink (input valid, action, glyph_code, reverse_video, move_count,
		escape_flag, output ready);
endinterface

interface atbd_cfg_if import atbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SCOLS_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: hdl/atbd_decode.sv
// Byte classifier: turns a request and byte into an action and glyph.
// Depends on atbd_pkg.
module atbd_decode import atbd_pkg::*; (
	input  logic       req_type,
	input  logic [7:0] data_byte,
	output dec_t       dec
);

	always_comb begin
		dec            = '0;
		dec.action     = ACT_GLYPH;
		if (req_type) begin
			dec.action    = ACT_RESET;
			dec.emu_reset = 1'b1;
		end else begin
			unique case (data_byte)
				BYTE_ESC: begin
					dec.action     = ACT_ESC;
					dec.esc_toggle = 1'b1;
				end
				BYTE_UP:        dec.action = ACT_UP;
				BYTE_DOWN:      dec.action = ACT_DOWN;
				BYTE_LEFT:      dec.action = ACT_LEFT;
				BYTE_RIGHT: begin
					dec.action    = ACT_RIGHT;
					dec.right_one = 1'b1;
				end
				BYTE_CLEAR:     dec.action = ACT_CLEAR_HOME;
				BYTE_BACKSPACE: dec.action = ACT_BACKSPACE;
				BYTE_TAB: begin
					dec.action = ACT_RIGHT;
					dec.tab    = 1'b1;
				end
				BYTE_EOL:       dec.action = ACT_NEWLINE;
				BYTE_ERASE_EOL: dec.action = ACT_ERASE_EOL;
				BYTE_INS_LINE:  dec.action = ACT_INS_LINE;
				BYTE_TAB_CLEAR: begin
					dec.action   = ACT_TAB_CLEAR;
					dec.stop_clr = 1'b1;
				end
				BYTE_TAB_SET: begin
					dec.action   = ACT_TAB_SET;
					dec.stop_set = 1'b1;
				end
				BYTE_BELL:      dec.action = ACT_BELL;
				BYTE_DELETE:    dec.action = ACT_DELETE;
				BYTE_INS_BLANK: dec.action = ACT_INS_BLANK;
				default: begin
					dec.glyph = GLYPH_ROM[data_byte[6:0]];
					dec.rev   = data_byte[7];
				end
			endcase
		end
	end

endmodule

// File: hdl/atbd_tab_unit.sv
// Tab-stop map with its update logic and the tab distance search.
// Depends on atbd_pkg.
module atbd_tab_unit import atbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             apply,
	input  tab_op_t          op,
	input  logic [COL_W-1:0] cur,
	input  logic [CNT_W-1:0] cols,
	output logic [7:0]       distance
);

	logic [MAX_COLUMNS-1:0] stops_q;
	logic [MAX_COLUMNS-1:0] cand;
	logic [MAX_COLUMNS-1:0] node_v [0:COL_W];
	logic [COL_W-1:0]       node_i [0:COL_W][0:MAX_COLUMNS-1];
	logic                   found;
	logic [COL_W-1:0]       first_idx;
	logic [CNT_W-1:0]       last_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stops_q <= '0;
		end else if (apply) begin
			for (int c = 0; c < MAX_COLUMNS; c++) begin
				if (op.load_default) begin
					stops_q[c] <= ((c % TAB_SPACING) == 0) && (CNT_W'(c) < cols);
				end else if (op.stop_set && (COL_W'(c) == cur)) begin
					stops_q[c] <= 1'b1;
				end else if (op.stop_clr && (COL_W'(c) == cur)) begin
					stops_q[c] <= 1'b0;
				end
			end
		end
	end

	// Candidate stops lie right of the cursor and inside the screen.
	always_comb begin
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			cand[c] = stops_q[c] && (COL_W'(c) > cur) && (CNT_W'(c) < cols);
		end
	end

	// Lowest set bit by a pairwise tree, one level per index bit.
	always_comb begin
		for (int l = 0; l <= COL_W; l++) begin
			node_v[l] = '0;
			for (int n = 0; n < MAX_COLUMNS; n++) begin
				node_i[l][n] = '0;
			end
		end
		node_v[0] = cand;
		for (int l = 0; l < COL_W; l++) begin
			for (int n = 0; n < (MAX_COLUMNS >> (l + 1)); n++) begin
				node_v[l+1][n] = node_v[l][2*n] | node_v[l][2*n+1];
				node_i[l+1][n] = node_v[l][2*n] ? node_i[l][2*n]
					: (node_i[l][2*n+1] | (COL_W'(1) << l));
			end
		end
		found     = node_v[COL_W][0];
		first_idx = node_i[COL_W][0];
	end

	// Without a stop, run to the last column; hold at zero there or beyond.
	always_comb begin
		if ((cols == '0) || ({1'b0, cur} >= (cols - CNT_W'(1)))) begin
			last_dist = '0;
		end else begin
			last_dist = cols - CNT_W'(1) - {1'b0, cur};
		end
		if (found) begin
			distance = 8'(first_idx - cur);
		end else if (last_dist > CNT_W'(255)) begin
			distance = 8'd255;
		end else begin
			distance = last_dist[7:0];
		end
	end

endmodule

// File: hdl/atascii_byte_decoder_with_tab_stops.sv
// ATASCII byte decoder: one request in, one result out, two-stage pipeline.
// Depends on atbd_pkg, atbd_if, atbd_decode and atbd_tab_unit.
//
// The block accepts one item every clock cycle while results are taken: the
// item is registered, then decoded, looked up in the tab-stop map and
// registered again as the result. The result-stage path is set by the
// find-first-set over the 256-bit tab-stop map. The tab map and
// the print-control flag are updated as each item moves into the result
// register, so items are handled strictly in order. The screen_columns
// register resets to 80; write it only while no item is in flight.
module atascii_byte_decoder_with_tab_stops import atbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	atbd_req_if.sink   req_ch,
	atbd_res_if.source res_ch,
	atbd_cfg_if.sink   cfg_ch
);

	logic               valid_s1;
	logic               req_type_s1;
	logic [7:0]         byte_s1;
	logic [COL_W-1:0]   cur_s1;
	logic               valid_s2;
	action_t            action_s2;
	logic [15:0]        glyph_s2;
	logic               rev_s2;
	logic [7:0]         move_s2;
	logic               flag_s2;
	logic               flag_q;
	logic [SCOLS_W-1:0] scols_q;
	logic [CNT_W-1:0]   cols;
	logic               advance;
	logic               fire;
	logic               flag_next;
	logic [7:0]         tab_dist;
	dec_t               dec;
	tab_op_t            tab_op;

	assign advance      = !valid_s2 || res_ch.ready;
	assign fire         = valid_s1 && advance;
	assign req_ch.ready = !valid_s1 || advance;
	assign cfg_ch.ready = 1'b1;

	assign cols = (scols_q > SCOLS_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : CNT_W'(scols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scols_q <= SCOLS_RESET;
		end else if (cfg_ch.valid) begin
			scols_q <= cfg_ch.data;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.valid && req_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			req_type_s1 <= req_ch.req_type;
			byte_s1     <= req_ch.data_byte;
			cur_s1      <= COL_W'(req_ch.cursor_column);
		end
	end

	atbd_decode u_decode (
		.req_type  (req_type_s1),
		.data_byte (byte_s1),
		.dec       (dec)
	);

	assign tab_op = '{load_default: dec.emu_reset, stop_set: dec.stop_set,
		stop_clr: dec.stop_clr};

	atbd_tab_unit u_tab (
		.clk      (clk),
		.arst_n   (arst_n),
		.apply    (fire),
		.op       (tab_op),
		.cur      (cur_s1),
		.cols     (cols),
		.distance (tab_dist)
	);

	always_comb begin
		flag_next = flag_q;
		if (dec.emu_reset) begin
			flag_next = 1'b1;
		end else if (dec.esc_toggle) begin
			flag_next = !flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q   <= 1'b1;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				flag_q <= flag_next;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Result stage.
	always_ff @(posedge clk) begin
		if (fire) begin
			action_s2 <= dec.action;
			glyph_s2  <= dec.glyph;
			rev_s2    <= dec.rev;
			flag_s2   <= flag_next;
			if (dec.tab) begin
				move_s2 <= tab_dist;
			end else if (dec.right_one) begin
				move_s2 <= 8'd1;
			end else begin
				move_s2 <= 8'd0;
			end
		end
	end

	assign res_ch.valid         = valid_s2;
	assign res_ch.action        = action_s2;
	assign res_ch.glyph_code    = glyph_s2;
	assign res_ch.reverse_video = rev_s2;
	assign res_ch.move_count    = move_s2;
	assign res_ch.escape_flag   = flag_s2;

endmodule
